FILE: rtl/tapmc_pkg.sv
// Package with shared types, codes and constants of the positioner mode controller.
`default_nettype none
package tapmc_pkg;
  localparam int PosBits = 12;

  typedef logic [PosBits-1:0] pos_t;

  typedef enum logic [1:0] {
    MODE_DISABLE = 2'd0,
    MODE_CALIB   = 2'd1,
    MODE_COMMAND = 2'd2,
    MODE_SERVICE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    AXIS_NONE = 2'd0,
    AXIS_X    = 2'd1,
    AXIS_Y    = 2'd2,
    AXIS_Z    = 2'd3
  } axis_t;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  localparam logic [15:0] ERR_INVALID  = 16'd0;
  localparam logic [15:0] ERR_DISABLED = 16'd1;
  localparam logic [15:0] ERR_BUSY     = 16'd2;

  localparam logic [3:0] CMD_HALT    = 4'd0;
  localparam logic [3:0] CMD_CALIB   = 4'd1;
  localparam logic [3:0] CMD_COMMAND = 4'd2;
  localparam logic [3:0] CMD_SERVICE = 4'd3;
  localparam logic [3:0] CMD_DISABLE = 4'd4;
  localparam logic [3:0] CMD_GOTO_X  = 4'd5;
  localparam logic [3:0] CMD_GOTO_Y  = 4'd6;
  localparam logic [3:0] CMD_GOTO_Z  = 4'd7;
  localparam logic [3:0] CMD_KEYSTEP = 4'd8;

  localparam logic [1:0] REG_HOLD    = 2'd0;
  localparam logic [1:0] REG_IDLE    = 2'd1;
  localparam logic [1:0] REG_POINTER = 2'd2;
  localparam logic [1:0] REG_BASE    = 2'd3;

  localparam logic [2:0] KEY_NONE    = 3'd0;
  localparam logic [2:0] KEY_X_MINUS = 3'd1;
  localparam logic [2:0] KEY_X_PLUS  = 3'd2;
  localparam logic [2:0] KEY_Y_MINUS = 3'd3;
  localparam logic [2:0] KEY_Y_PLUS  = 3'd4;
  localparam logic [2:0] KEY_Z_MINUS = 3'd5;
  localparam logic [2:0] KEY_Z_PLUS  = 3'd6;
  localparam logic [2:0] KEY_SPARE   = 3'd7;

  localparam logic [1:0] SCROLL_MID  = 2'd0;
  localparam logic [1:0] SCROLL_FAR  = 2'd1;
  localparam logic [1:0] SCROLL_LEFT = 2'd2;
  localparam logic [1:0] SCROLL_NONE = 2'd3;

  localparam int XMax    = 2580;
  localparam int XMid    = 1290;
  localparam int YMax    = 700;
  localparam int ZMaxKey = 1400;
  localparam int ZMaxCmd = 1350;
  localparam int ZCalib  = 1000;
  localparam int Step    = 10;
  localparam int Snap    = 20;

  // One accepted item as held in the input register.
  typedef struct packed {
    logic       op;
    logic [3:0] command_code;
    logic [7:0] param_low;
    logic [7:0] param_high;
    logic [2:0] key_code;
    logic       tool_present;
    logic       needle_present;
    logic       y_is_up;
    logic [1:0] scroll_place;
  } item_t;

  // Controller state carried from item to item.
  typedef struct packed {
    mode_t       current_mode;
    mode_t       requested_mode;
    logic        mode_entry;
    logic [11:0] hold_count;
    logic [11:0] idle_count;
    logic        key_latched;
    logic        keystep_on;
    logic        general_enable;
    logic        keyboard_enable;
    logic        power_state;
    logic        collision_state;
    pos_t [2:0]  axis_position;
    pos_t [2:0]  axis_target;
    axis_t       active_axis;
    logic        abort_pending;
  } ctl_state_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  reply_kind;
    logic [15:0] reply_value;
    logic        mode_done;
    logic        move_done;
    logic        abort_done;
    logic [11:0] x_now;
    logic [9:0]  y_now;
    logic [10:0] z_now;
    logic [1:0]  mode_now;
    logic        power_on;
    logic        collision;
    logic [1:0]  moving_axis;
  } result_t;

  typedef struct packed {
    logic [11:0] hold_ticks;
    logic [11:0] idle_ticks;
    logic [11:0] pointer_width;
    logic [11:0] base_width;
  } cfg_t;
endpackage
`default_nettype wire

FILE: rtl/tapmc_collide.sv
// Collision check of the pointer carriage against the scrolled base region.
`default_nettype none
module tapmc_collide
  import tapmc_pkg::*;
(
  input  wire logic [11:0] x_pos,
  input  wire logic [11:0] pointer_width,
  input  wire logic [11:0] base_width,
  input  wire logic [1:0]  scroll_place,
  output logic             hit
);
  logic signed [14:0] pmin, pmax, bmin, bmax;

  always_comb begin
    pmin = $signed({3'b000, x_pos}) - $signed({4'b0000, pointer_width[11:1]});
    pmax = $signed({3'b000, x_pos}) + $signed({4'b0000, pointer_width[11:1]});
    bmin = '0;
    bmax = '0;
    hit  = 1'b0;
    unique case (scroll_place)
      SCROLL_MID: begin
        bmin = 15'(XMid) - $signed({4'b0000, base_width[11:1]});
        bmax = 15'(XMid) + $signed({4'b0000, base_width[11:1]});
      end
      SCROLL_FAR: begin
        bmin = 15'(XMax) - $signed({3'b000, base_width});
        bmax = 15'(XMax);
      end
      SCROLL_LEFT: begin
        bmin = '0;
        bmax = $signed({3'b000, base_width});
      end
      default: begin
        bmin = 15'sd1;
        bmax = 15'sd0;
      end
    endcase
    if (scroll_place != SCROLL_NONE) begin
      hit = (pmin <= bmax && pmin >= bmin) || (pmax <= bmax && pmax >= bmin);
    end
  end
endmodule
`default_nettype wire

FILE: rtl/tapmc_core.sv
// Next-state and result logic for one item: commands, mode rules and axis motion.
`default_nettype none
module tapmc_core
  import tapmc_pkg::*;
(
  input  wire item_t      item,
  input  wire cfg_t       cfg,
  input  wire ctl_state_t st,
  output ctl_state_t      st_next,
  output result_t         res
);
  ctl_state_t s;
  logic       pressed;
  logic       hit;
  logic       needle_en;
  logic       mode_done, move_done, abort_done;
  logic [1:0] kind;
  logic [15:0] value;
  logic [15:0] req_pos;
  logic [1:0]  ax;
  logic [15:0] lim;
  logic        calib;
  logic        stop_rules;
  logic [1:0]  ka;
  pos_t        kpos, ktop;
  logic signed [PosBits+1:0] d;

  tapmc_collide u_collide (
    .x_pos         (s.axis_position[0][11:0]),
    .pointer_width (cfg.pointer_width),
    .base_width    (cfg.base_width),
    .scroll_place  (item.scroll_place),
    .hit           (hit)
  );

  // Stage A: command or mode rules, producing s (pre-collision state).
  always_comb begin
    s          = st;
    kind       = KIND_TICK;
    value      = '0;
    mode_done  = 1'b0;
    pressed    = item.key_code != KEY_NONE;
    req_pos    = {item.param_high, item.param_low};
    ax         = 2'd0;
    lim        = '0;
    calib      = 1'b0;
    stop_rules = 1'b0;
    ka         = 2'(({1'b0, item.key_code} - 4'd1) >> 1);
    kpos       = '0;
    ktop       = '0;
    if (item.op) begin
      kind = KIND_ACCEPT;
      if (item.command_code == CMD_HALT) begin
        s.abort_pending = 1'b1;
      end else if (item.command_code >= CMD_CALIB && item.command_code <= CMD_DISABLE) begin
        s.requested_mode = (item.command_code == CMD_DISABLE) ? MODE_DISABLE :
                           mode_t'(item.command_code[1:0]);
      end else if (item.command_code >= CMD_GOTO_X && item.command_code <= CMD_GOTO_Z) begin
        ax  = 2'(item.command_code - CMD_GOTO_X);
        lim = (ax == 2'd0) ? 16'(XMax) : ((ax == 2'd1) ? 16'(YMax) : 16'(ZMaxCmd));
        if (req_pos == 16'(st.axis_position[ax])) begin
          kind  = KIND_DONE;
          value = req_pos;
        end else if (req_pos > lim) begin
          kind  = KIND_ERROR;
          value = ERR_INVALID;
        end else if (st.current_mode != MODE_COMMAND || !st.power_state) begin
          kind  = KIND_ERROR;
          value = ERR_DISABLED;
        end else if (st.active_axis != AXIS_NONE) begin
          kind  = KIND_ERROR;
          value = ERR_BUSY;
        end else begin
          s.axis_target[ax] = req_pos[PosBits-1:0];
          s.active_axis     = axis_t'(ax + 2'd1);
        end
      end else if (item.command_code == CMD_KEYSTEP) begin
        kind         = KIND_DONE;
        s.keystep_on = st.current_mode == MODE_COMMAND && item.param_low != 8'd0;
      end else begin
        kind  = KIND_ERROR;
        value = ERR_DISABLED;
      end
    end else begin
      if (st.requested_mode != st.current_mode) begin
        s.current_mode = st.requested_mode;
        s.mode_entry   = 1'b1;
        mode_done      = 1'b1;
      end
      unique case (s.current_mode)
        MODE_DISABLE: begin
          if (s.mode_entry) begin
            s.mode_entry = 1'b0;
            s.hold_count = cfg.hold_ticks;
          end
          s.general_enable  = 1'b0;
          s.keyboard_enable = 1'b0;
          s.keystep_on      = 1'b0;
          if (!pressed) s.hold_count = cfg.hold_ticks;
          else if (s.hold_count != '0) s.hold_count = s.hold_count - 12'd1;
          if (s.hold_count == '0) s.requested_mode = MODE_CALIB;
        end
        MODE_CALIB, MODE_COMMAND: begin
          calib = s.current_mode == MODE_CALIB;
          if (s.mode_entry) begin
            s.mode_entry = 1'b0;
            if (calib) s.idle_count = cfg.idle_ticks;
            s.key_latched = pressed;
          end
          s.general_enable = 1'b1;
          if (calib) begin
            s.keyboard_enable = 1'b1;
            s.keystep_on      = 1'b0;
            if (pressed) s.idle_count = cfg.idle_ticks;
            else if (s.idle_count != '0) s.idle_count = s.idle_count - 12'd1;
            if (s.idle_count == '0) begin
              s.requested_mode = MODE_DISABLE;
              stop_rules       = 1'b1;
            end
          end else begin
            s.keyboard_enable = s.keystep_on;
          end
          if (!stop_rules) begin
            if (s.key_latched) begin
              if (!pressed) s.key_latched = 1'b0;
            end else if (pressed) begin
              s.key_latched = 1'b1;
              if (calib) begin
                unique case (item.key_code)
                  KEY_X_MINUS: s.axis_target[0] = '0;
                  KEY_X_PLUS:  s.axis_target[0] =
                    (s.axis_target[0] == pos_t'(XMid)) ? pos_t'(XMax) : pos_t'(XMid);
                  KEY_Y_MINUS: s.axis_target[1] = '0;
                  KEY_Y_PLUS:  s.axis_target[1] = pos_t'(YMax);
                  KEY_Z_MINUS: s.axis_target[2] = '0;
                  KEY_Z_PLUS:  s.axis_target[2] = pos_t'(ZCalib);
                  default: ;
                endcase
                if (item.key_code != KEY_SPARE) begin
                  s.active_axis = axis_t'(ka + 2'd1);
                end
              end else if (s.keystep_on && item.key_code != KEY_SPARE) begin
                kpos = s.axis_position[ka];
                ktop = (ka == 2'd0) ? pos_t'(XMax) :
                       ((ka == 2'd1) ? pos_t'(YMax) : pos_t'(ZMaxKey));
                if (item.key_code[0]) begin
                  s.axis_target[ka] = (kpos < pos_t'(Step)) ? '0 : kpos - pos_t'(Step);
                end else begin
                  s.axis_target[ka] = (kpos > ktop - pos_t'(Step)) ? ktop :
                                      kpos + pos_t'(Step);
                end
                s.active_axis = axis_t'(ka + 2'd1);
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Stage B: enables, collision and axis motion on ticks.
  always_comb begin
    st_next    = s;
    move_done  = 1'b0;
    abort_done = 1'b0;
    needle_en  = item.tool_present ? !item.needle_present : 1'b1;
    d          = '0;
    if (!item.op) begin
      if (!s.general_enable) st_next.power_state = 1'b0;
      else if (pressed && s.keyboard_enable) st_next.power_state = 1'b1;
      else st_next.power_state = needle_en;
      st_next.collision_state = !item.y_is_up && hit;
      if (s.active_axis != AXIS_NONE) begin
        d = $signed({2'b00, s.axis_position[2'(s.active_axis) - 2'd1]}) -
            $signed({2'b00, s.axis_target[2'(s.active_axis) - 2'd1]});
        if (!st_next.power_state || s.abort_pending || st_next.collision_state) begin
          st_next.active_axis = AXIS_NONE;
        end else if (d < (PosBits+2)'(Snap) && d > -(PosBits+2)'(Snap)) begin
          st_next.axis_position[2'(s.active_axis) - 2'd1] =
            s.axis_target[2'(s.active_axis) - 2'd1];
          st_next.active_axis = AXIS_NONE;
          move_done = 1'b1;
        end else if (d > 0) begin
          st_next.axis_position[2'(s.active_axis) - 2'd1] =
            s.axis_position[2'(s.active_axis) - 2'd1] - pos_t'(Step);
        end else begin
          st_next.axis_position[2'(s.active_axis) - 2'd1] =
            s.axis_position[2'(s.active_axis) - 2'd1] + pos_t'(Step);
        end
      end
      if (s.abort_pending) begin
        st_next.abort_pending = 1'b0;
        abort_done = 1'b1;
      end
    end
    res.reply_kind  = kind;
    res.reply_value = value;
    res.mode_done   = mode_done;
    res.move_done   = move_done;
    res.abort_done  = abort_done;
    res.x_now       = st_next.axis_position[0][11:0];
    res.y_now       = st_next.axis_position[1][9:0];
    res.z_now       = st_next.axis_position[2][10:0];
    res.mode_now    = st_next.current_mode;
    res.power_on    = st_next.power_state;
    res.collision   = st_next.collision_state;
    res.moving_axis = st_next.active_axis;
  end
endmodule
`default_nettype wire

FILE: rtl/three_axis_positioner_mode_controller.sv
// Top level of the three-axis positioner mode controller.
// An accepted item is held in the input register and worked out in one pass of logic
// by the core; its result item is captured in the result register when the pipeline advances.
// Throughput: one item per cycle; the input register and the result register both
// advance whenever the result register is empty or being taken.
// Reset (rst, synchronous): disable mode, axes at zero, no move, registers at their
// defaults (hold 20, idle 1200, pointer 200, base 400); no item is held.
`default_nettype none
module three_axis_positioner_mode_controller
  import tapmc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        op,
  input  wire logic [3:0]  command_code,
  input  wire logic [7:0]  param_low,
  input  wire logic [7:0]  param_high,
  input  wire logic [2:0]  key_code,
  input  wire logic        tool_present,
  input  wire logic        needle_present,
  input  wire logic        y_is_up,
  input  wire logic [1:0]  scroll_place,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [11:0] cfg_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       reply_kind,
  output logic [15:0]      reply_value,
  output logic             mode_done,
  output logic             move_done,
  output logic             abort_done,
  output logic [11:0]      x_now,
  output logic [9:0]       y_now,
  output logic [10:0]      z_now,
  output logic [1:0]       mode_now,
  output logic             power_on,
  output logic             collision,
  output logic [1:0]       moving_axis
);
  item_t      item;
  logic       item_valid;
  cfg_t       cfg;
  ctl_state_t st, st_next;
  result_t    res, res_q;
  logic       advance;

  // The pipeline moves when the result slot is free or its item is taken.
  assign advance   = !out_valid || out_ready;
  assign in_ready  = advance;
  assign cfg_ready = 1'b1;

  tapmc_core u_core (
    .item    (item),
    .cfg     (cfg),
    .st      (st),
    .st_next (st_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_ticks    <= 12'd20;
      cfg.idle_ticks    <= 12'd1200;
      cfg.pointer_width <= 12'd200;
      cfg.base_width    <= 12'd400;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HOLD:    cfg.hold_ticks    <= cfg_data;
        REG_IDLE:    cfg.idle_ticks    <= cfg_data;
        REG_POINTER: cfg.pointer_width <= cfg_data;
        REG_BASE:    cfg.base_width    <= cfg_data;
      endcase
    end
  end

  // Input register: the item waits here for one pass through the core.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (advance) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      item <= '{op, command_code, param_low, param_high, key_code,
                tool_present, needle_present, y_is_up, scroll_place};
    end
  end

  // State and result register update together when an item leaves the core.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.current_mode    <= MODE_DISABLE;
      st.requested_mode  <= MODE_DISABLE;
      st.mode_entry      <= 1'b1;
      st.hold_count      <= 12'd20;
      st.idle_count      <= 12'd1200;
      st.key_latched     <= 1'b0;
      st.keystep_on      <= 1'b0;
      st.general_enable  <= 1'b0;
      st.keyboard_enable <= 1'b0;
      st.power_state     <= 1'b0;
      st.collision_state <= 1'b0;
      st.axis_position   <= '0;
      st.axis_target     <= '0;
      st.active_axis     <= AXIS_NONE;
      st.abort_pending   <= 1'b0;
      out_valid          <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
      if (item_valid) st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid) res_q <= res;
  end

  assign reply_kind  = res_q.reply_kind;
  assign reply_value = res_q.reply_value;
  assign mode_done   = res_q.mode_done;
  assign move_done   = res_q.move_done;
  assign abort_done  = res_q.abort_done;
  assign x_now       = res_q.x_now;
  assign y_now       = res_q.y_now;
  assign z_now       = res_q.z_now;
  assign mode_now    = res_q.mode_now;
  assign power_on    = res_q.power_on;
  assign collision   = res_q.collision;
  assign moving_axis = res_q.moving_axis;

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(res_q))
    else $error("result changed while stalled");
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !(advance && item_valid) |=> $stable(st))
    else $error("state changed without an item");
  a_done_tick: assert property (@(posedge clk) disable iff (rst)
    out_valid && reply_kind != KIND_TICK |-> !mode_done && !move_done && !abort_done)
    else $error("tick event on a command reply");
  a_move_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && move_done |-> moving_axis == AXIS_NONE)
    else $error("move done with axis still active");
endmodule
`default_nettype wire
